[sv/slpg_pkg.sv]
`default_nettype none

package slpg_pkg;

  localparam int unsigned PhaseW  = 32;
  localparam int unsigned CntW    = $clog2(PhaseW);
  localparam int unsigned StatusW = 3;
  localparam int unsigned PerW    = 5;
  localparam int unsigned LvlW    = 7;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [StatusW-1:0] {
    ST_BOOT    = 3'd0,
    ST_TEST    = 3'd1,
    ST_WAITING = 3'd2,
    ST_OK      = 3'd3,
    ST_ERROR   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_DIV,
    CTL_DONE
  } ctl_state_e;

  typedef struct packed {
    logic set_status;
    logic start;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

  localparam logic [LvlW-1:0] ErrorLevel = 7'd90;

  function automatic logic [PerW-1:0] blink_period(input logic [StatusW-1:0] st);
    logic [PerW-1:0] per;
    case (st)
      ST_BOOT:    per = 5'd25;
      ST_TEST:    per = 5'd5;
      ST_WAITING: per = 5'd25;
      ST_OK:      per = 5'd12;
      ST_ERROR:   per = 5'd2;
      default:    per = 5'd25;
    endcase
    return per;
  endfunction

  // x / 3 for 7-bit x: (x * 171) >> 9
  function automatic logic [LvlW-1:0] div3(input logic [LvlW-1:0] x);
    logic [15:0] prod;
    prod = 16'(x) * 16'd171;
    return prod[15:9];
  endfunction

endpackage

`default_nettype wire

[sv/slpg_ctrl.sv]
`default_nettype none

module slpg_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_set_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire slpg_pkg::sts_t sts_i,
  output slpg_pkg::cmd_t     cmd_o
);

  slpg_pkg::ctl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      slpg_pkg::CTL_IDLE: begin
        if (in_valid_i && !in_set_i) begin
          state_d = slpg_pkg::CTL_DIV;
        end
      end
      slpg_pkg::CTL_DIV: begin
        if (sts_i.div_last) begin
          state_d = slpg_pkg::CTL_DONE;
        end
      end
      slpg_pkg::CTL_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = slpg_pkg::CTL_IDLE;
        end
      end
      default: state_d = slpg_pkg::CTL_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      slpg_pkg::CTL_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.set_status  = in_valid_i && in_set_i;
        cmd_o.start       = in_valid_i && !in_set_i;
      end
      slpg_pkg::CTL_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      slpg_pkg::CTL_DONE: begin
        cmd_o.load_out = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slpg_pkg::CTL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[sv/slpg_datapath.sv]
`default_nettype none

module slpg_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire slpg_pkg::cmd_t                  cmd_i,
  output slpg_pkg::sts_t                       sts_o,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_wdata_i,
  input  wire logic [slpg_pkg::StatusW-1:0]    new_status_i,
  input  wire logic                            fifo_full_i,
  output logic [slpg_pkg::OutDataW-1:0]        out_data_o
);

  localparam int unsigned PhaseW = slpg_pkg::PhaseW;
  localparam int unsigned CntW   = slpg_pkg::CntW;
  localparam int unsigned PerW   = slpg_pkg::PerW;
  localparam int unsigned LvlW   = slpg_pkg::LvlW;

  logic [slpg_pkg::StatusW-1:0] status_q;
  logic [PhaseW-1:0]            phase_q;
  logic                         colour_q;
  logic                         full_q;
  logic [PhaseW-1:0]            sh_q;
  logic [PerW-1:0]              rem_q, rem_d;
  logic [CntW-1:0]              cnt_q;
  logic [slpg_pkg::OutDataW-1:0] out_q;

  logic [PhaseW-1:0] phase_inc;
  logic [PerW-1:0]   per;
  logic [PerW:0]     rem_sh;
  logic [3:0]        tri_v;
  logic [LvlW-1:0]   lvl;
  logic [7:0]        r_b, g_b, b_b;
  logic              lamp;
  logic [31:0]       word;
  logic              push;

  assign phase_inc = phase_q + PhaseW'(1);
  assign per       = slpg_pkg::blink_period(status_q);
  assign rem_sh    = {rem_q, sh_q[PhaseW-1]};

  always_comb begin
    if (rem_sh >= {1'b0, per}) begin
      rem_d = PerW'(rem_sh - {1'b0, per});
    end else begin
      rem_d = rem_sh[PerW-1:0];
    end
  end

  assign sts_o.div_last = (cnt_q == CntW'(PhaseW - 1));

  // triangle over 32 ticks; 31 - p for the falling half
  assign tri_v = phase_q[4] ? ~phase_q[3:0] : phase_q[3:0];

  always_comb begin
    if (status_q == slpg_pkg::ST_ERROR) begin
      lvl = phase_q[1] ? slpg_pkg::ErrorLevel : '0;
    end else begin
      lvl = {1'b0, 4'(tri_v + 4'd1), 2'b00};
      if (tri_v == 4'hf) begin
        lvl = 7'd64;
      end
    end
  end

  always_comb begin
    r_b = '0;
    g_b = '0;
    b_b = '0;
    case (status_q)
      slpg_pkg::ST_BOOT:    b_b = 8'(lvl);
      slpg_pkg::ST_TEST: begin
        r_b = 8'(lvl);
        g_b = 8'(lvl);
      end
      slpg_pkg::ST_WAITING: begin
        r_b = 8'(slpg_pkg::div3(lvl));
        b_b = 8'(lvl);
      end
      slpg_pkg::ST_OK:      g_b = 8'(lvl);
      default:              r_b = 8'(lvl);
    endcase
  end

  always_comb begin
    lamp = 1'b0;
    word = '0;
    push = 1'b0;
    if (colour_q) begin
      word = {g_b, r_b, b_b, 8'h00};
      push = !full_q;
    end else begin
      lamp = (rem_q < (per >> 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= slpg_pkg::ST_BOOT;
      phase_q  <= '0;
      colour_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        colour_q <= cfg_wdata_i;
      end
      if (cmd_i.set_status && (new_status_i <= slpg_pkg::ST_ERROR)) begin
        status_q <= new_status_i;
      end
      if (cmd_i.start) begin
        phase_q <= phase_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sh_q   <= phase_inc;
      rem_q  <= '0;
      cnt_q  <= '0;
      full_q <= fifo_full_i;
    end else if (cmd_i.div_step) begin
      sh_q  <= {sh_q[PhaseW-2:0], 1'b0};
      rem_q <= rem_d;
      cnt_q <= cnt_q + CntW'(1);
    end
    if (cmd_i.load_out) begin
      out_q <= {3'b000, status_q, push, word, lamp};
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

[sv/status_led_pattern_generator.sv]
`default_nettype none

// Status light heartbeat generator. A request with tuser = 1 sets the status
// from tdata[2:0] (codes above error are ignored) and yields no result. A
// request with tuser = 0 is a tick: the 32-bit phase advances and one result is
// presented after a bit-serial phase-mod-period divider that runs one phase bit
// per cycle has finished and the output register has been loaded. The next
// request is taken only once that result is in the output register, and later
// still while an earlier result waits there. cfg_we_i/cfg_wdata_i select
// colour mode (1) or plain lamp (0); the user must write them only while the
// block is idle. The block itself does not enforce this.
module status_led_pattern_generator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_wdata_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [2:0] new_status, [3] fifo_full
  input  wire logic [slpg_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] action
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [0] lamp_on, [32:1] pixel_word, [33] pixel_push, [36:34] current_status
  output logic [slpg_pkg::OutDataW-1:0]          m_axis_tdata
);

  slpg_pkg::cmd_t cmd;
  slpg_pkg::sts_t sts;

  slpg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_set_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  slpg_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .new_status_i (s_axis_tdata[slpg_pkg::StatusW-1:0]),
    .fifo_full_i  (s_axis_tdata[slpg_pkg::StatusW]),
    .out_data_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

[verif/tb_status_led_pattern_generator.sv]
`default_nettype none

module tb_status_led_pattern_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned TailCycles    = 40;

  // same order as m_axis_tdata[36:0]
  typedef struct packed {
    slpg_pkg::status_e st;
    logic              push;
    logic [31:0]       word;
    logic              lamp;
  } light_result_t;

  class light_scoreboard;
    slpg_pkg::status_e held_status;
    logic [31:0]       phase_q;
    bit                colour;
    light_result_t     due_q[$];
    int                errors;

    function new();
      held_status = slpg_pkg::ST_BOOT;
      phase_q     = '0;
      colour      = 1'b0;
      errors      = 0;
    endfunction

    function void set_colour(input bit v);
      colour = v;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function light_result_t next_light(input logic full);
      light_result_t res;
      logic [7:0]    lvl;
      logic [7:0]    g;
      logic [7:0]    r;
      logic [7:0]    b;
      logic [4:0]    p;
      logic [4:0]    ramp;
      int unsigned   per;
      res = '0;
      res.st = held_status;
      phase_q = phase_q + 32'd1;
      if (colour) begin
        if (held_status == slpg_pkg::ST_ERROR) begin
          lvl = phase_q[1] ? 8'd90 : 8'd0;
        end else begin
          p = phase_q[4:0];
          ramp = (p < 5'd16) ? p : 5'd31 - p;
          lvl = 8'd4 + {1'b0, ramp, 2'b00};
        end
        g = '0;
        r = '0;
        b = '0;
        case (held_status)
          slpg_pkg::ST_BOOT: begin
            b = lvl;
          end
          slpg_pkg::ST_TEST: begin
            r = lvl;
            g = lvl;
          end
          slpg_pkg::ST_WAITING: begin
            r = lvl / 8'd3;
            b = lvl;
          end
          slpg_pkg::ST_OK: begin
            g = lvl;
          end
          default: begin
            r = lvl;
          end
        endcase
        res.word = {g, r, b, 8'h00};
        res.push = !full;
      end else begin
        case (held_status)
          slpg_pkg::ST_TEST:  per = 5;
          slpg_pkg::ST_OK:    per = 12;
          slpg_pkg::ST_ERROR: per = 2;
          default:            per = 25;
        endcase
        res.lamp = ((phase_q % per) < (per / 2));
      end
      return res;
    endfunction

    function void note_request(input logic act, input logic [2:0] ns, input logic full);
      if (act) begin
        if (ns <= slpg_pkg::ST_ERROR) held_status = slpg_pkg::status_e'(ns);
      end else begin
        due_q.push_back(next_light(full));
      end
    endfunction

    function void check_result(input logic [slpg_pkg::OutDataW-1:0] d);
      light_result_t got;
      light_result_t exp_r;
      got = d[36:0];
      if (due_q.size() == 0) begin
        $display("%0t: result expected none got %h", $time, d);
        errors++;
      end else begin
        exp_r = due_q.pop_front();
        if (got.lamp !== exp_r.lamp) begin
          $display("%0t: lamp_on expected %0d got %0d", $time, exp_r.lamp, got.lamp);
          errors++;
        end
        if (got.word !== exp_r.word) begin
          $display("%0t: pixel_word expected %h got %h", $time, exp_r.word, got.word);
          errors++;
        end
        if (got.push !== exp_r.push) begin
          $display("%0t: pixel_push expected %0d got %0d", $time, exp_r.push, got.push);
          errors++;
        end
        if (got.st !== exp_r.st) begin
          $display("%0t: current_status expected %0d got %0d", $time, exp_r.st, got.st);
          errors++;
        end
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic                          cfg_wdata_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [slpg_pkg::InDataW-1:0]  s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [slpg_pkg::OutDataW-1:0] m_axis_tdata;

  bit              calm;
  int unsigned     quiet_cycles;
  light_scoreboard sb = new();

  status_led_pattern_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_request(input bit act, input bit [2:0] ns, input bit full);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0000, full, ns};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(act, ns, full);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_colour_mode(input bit v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_colour(v);
  endtask

  // result side backpressure
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_status_led_pattern_generator NOT OK");
    $finish;
  end

  initial begin
    bit colour_sel;
    calm          = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain lamp: every status code, unknown codes keep the held one
    write_colour_mode(1'b0);
    for (int s = 0; s < 8; s++) begin
      send_request(1'b1, 3'(s), 1'(s));
      send_request(1'b0, 3'(7 - s), 1'(s));
    end
    drain();

    // colour words: error blink both ways, fifo full both ways
    write_colour_mode(1'b1);
    send_request(1'b1, slpg_pkg::ST_ERROR, 1'b0);
    for (int k = 0; k < 4; k++) send_request(1'b0, 3'b111, 1'(k));
    send_request(1'b1, slpg_pkg::ST_TEST, 1'b1);
    send_request(1'b0, 3'b000, 1'b0);
    send_request(1'b1, 3'd7, 1'b0);
    send_request(1'b0, 3'b101, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      colour_sel = (ph != 1 && ph != 4);
      calm = (ph == 5);
      write_colour_mode(colour_sel);
      for (int n = 0; n < 290; n++) begin
        send_request($urandom_range(0, 3) == 0, 3'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)));
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_status_led_pattern_generator OK");
    end else begin
      $display("tb_status_led_pattern_generator NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
